// ----- sv/cas_pkg.sv -----
// ----------------------------------------------------------------------------
// cas_pkg
// Shared types and constants of the convolution address sequencer: channel
// payloads, configuration register indexes and the control token that
// travels from the sequencer to the address datapath.
// ----------------------------------------------------------------------------
package cas_pkg;

  // Address widths on the result channel
  localparam int IN_ADDR_W = 25;
  localparam int W_ADDR_W  = 24;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int BYTE_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_DEPTHS            = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_DIMS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_DIMS        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_DIMS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_PLANE_SIZE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_PLANE_LAST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKWARD_MODE     = 3'd6;

  // One tick of input
  typedef struct packed {
    logic start_req;
    logic sink_busy;
  } in_t;

  // One tick of result
  typedef struct packed {
    logic                 mac_valid;
    logic [IN_ADDR_W-1:0] input_addr;
    logic [W_ADDR_W-1:0]  weight_addr;
    logic                 pixel_start;
    logic                 pixel_done;
    logic                 layer_done;
  } out_t;

  // Per-tick control token from the sequencer to the address datapath
  typedef struct packed {
    logic valid;
    logic load;
    logic mac_valid;
    logic pixel_start;
    logic pixel_done;
    logic layer_done;
  } tok_t;

endpackage

// ----- sv/cas_ctrl.sv -----
// ----------------------------------------------------------------------------
// cas_ctrl
// Loop sequencer: walks output pixels and, per pixel, input channels and
// kernel taps with backward-mode edge clipping. The state registers after
// an accepted tick form the first pipeline stage.
// ----------------------------------------------------------------------------
module cas_ctrl #(
  parameter int DIM_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  cas_pkg::in_t               in_data,
  input  logic                       adv,
  input  logic [DIM_BITS-1:0]        out_depth_last,
  input  logic [DIM_BITS-1:0]        in_depth_last,
  input  logic [DIM_BITS-1:0]        out_height_last,
  input  logic [DIM_BITS-1:0]        out_width_last,
  input  logic [DIM_BITS-1:0]        in_height_last,
  input  logic [DIM_BITS-1:0]        in_width_last,
  input  logic [DIM_BITS-1:0]        ker_height_last,
  input  logic [DIM_BITS-1:0]        ker_width_last,
  input  logic                       bwd,
  output cas_pkg::tok_t              tok,
  output logic [DIM_BITS-1:0]        out_chan,
  output logic [DIM_BITS-1:0]        in_chan,
  output logic [DIM_BITS-1:0]        ker_row,
  output logic [DIM_BITS-1:0]        ker_col,
  output logic signed [DIM_BITS:0]   win_y,
  output logic signed [DIM_BITS:0]   win_x
);
  import cas_pkg::*;

  localparam int D = DIM_BITS;

  typedef enum logic [2:0] {
    PH_BOOT, PH_IDLE, PH_PSTART, PH_MAC, PH_PDONE, PH_BUSY, PH_GAP, PH_LDONE
  } phase_t;

  phase_t       phase, phase_next;
  logic [D-1:0] out_row, out_col;
  logic [D-1:0] out_chan_next, out_row_next, out_col_next;
  logic [D-1:0] in_chan_next, ker_row_next, ker_col_next;
  logic         load, load_next;
  logic         valid1;
  logic         accept;
  logic [D-1:0] row_first, col_first;
  logic [D:0]   ker_row_inc, ker_col_inc, in_chan_inc;
  logic [D:0]   out_row_inc, out_col_inc, out_chan_inc;
  logic         first_row_ok, first_col_ok;
  logic         col_step_ok, row_step_ok, chan_step_ok;

  // Check one kernel offset against the kernel size and, in backward mode,
  // against the input edge
  function automatic logic fit_ok(
    input logic [D:0]          fy,
    input logic signed [D:0]   w,
    input logic [D-1:0]        lim_k,
    input logic [D-1:0]        lim_i,
    input logic                b
  );
    logic signed [D+1:0] pos;
    pos = $signed({w[D], w}) + $signed({1'b0, fy});
    return (fy <= {1'b0, lim_k}) && (!b || (pos <= $signed({2'b00, lim_i})));
  endfunction

  assign accept = in_valid && adv;

  // Window origin of the current output pixel
  assign win_y = $signed({1'b0, out_row}) - (bwd ? $signed({1'b0, ker_height_last})
                                                  : $signed((D+1)'(0)));
  assign win_x = $signed({1'b0, out_col}) - (bwd ? $signed({1'b0, ker_width_last})
                                                  : $signed((D+1)'(0)));

  // First usable kernel row and column after clipping
  assign row_first = (win_y < 0) ? D'(-win_y) : '0;
  assign col_first = (win_x < 0) ? D'(-win_x) : '0;

  assign ker_row_inc  = {1'b0, ker_row} + (D+1)'(1);
  assign ker_col_inc  = {1'b0, ker_col} + (D+1)'(1);
  assign in_chan_inc  = {1'b0, in_chan} + (D+1)'(1);
  assign out_row_inc  = {1'b0, out_row} + (D+1)'(1);
  assign out_col_inc  = {1'b0, out_col} + (D+1)'(1);
  assign out_chan_inc = {1'b0, out_chan} + (D+1)'(1);

  assign first_row_ok = fit_ok({1'b0, row_first}, win_y, ker_height_last,
                               in_height_last, bwd);
  assign first_col_ok = fit_ok({1'b0, col_first}, win_x, ker_width_last,
                               in_width_last, bwd);
  assign col_step_ok  = fit_ok(ker_col_inc, win_x, ker_width_last, in_width_last, bwd);
  assign row_step_ok  = fit_ok(ker_row_inc, win_y, ker_height_last, in_height_last, bwd)
                        && first_col_ok;
  assign chan_step_ok = (in_chan_inc <= {1'b0, in_depth_last}) && first_row_ok
                        && first_col_ok;

  // Advance the loop nest by one tick
  always_comb begin
    phase_next    = phase;
    out_chan_next = out_chan;
    out_row_next  = out_row;
    out_col_next  = out_col;
    in_chan_next  = in_chan;
    ker_row_next  = ker_row;
    ker_col_next  = ker_col;
    load_next     = 1'b0;
    unique case (phase)
      PH_BOOT: begin
        phase_next = PH_IDLE;
      end
      PH_IDLE: begin
        if (in_data.start_req) begin
          out_chan_next = '0;
          out_row_next  = '0;
          out_col_next  = '0;
          phase_next    = PH_PSTART;
        end
      end
      PH_PSTART: begin
        if (first_row_ok && first_col_ok) begin
          in_chan_next = '0;
          ker_row_next = row_first;
          ker_col_next = col_first;
          load_next    = 1'b1;
          phase_next   = PH_MAC;
        end else begin
          phase_next = PH_PDONE;
        end
      end
      PH_MAC: begin
        priority if (col_step_ok) begin
          ker_col_next = ker_col_inc[D-1:0];
          load_next    = 1'b1;
        end else if (row_step_ok) begin
          ker_row_next = ker_row_inc[D-1:0];
          ker_col_next = col_first;
          load_next    = 1'b1;
        end else if (chan_step_ok) begin
          in_chan_next = in_chan_inc[D-1:0];
          ker_row_next = row_first;
          ker_col_next = col_first;
          load_next    = 1'b1;
        end else begin
          phase_next = PH_PDONE;
        end
      end
      PH_PDONE: begin
        phase_next = PH_BUSY;
      end
      PH_BUSY: begin
        if (!in_data.sink_busy) begin
          priority if (out_col_inc <= {1'b0, out_width_last}) begin
            out_col_next = out_col_inc[D-1:0];
            phase_next   = PH_PSTART;
          end else if (out_row_inc <= {1'b0, out_height_last}) begin
            out_row_next = out_row_inc[D-1:0];
            out_col_next = '0;
            phase_next   = PH_PSTART;
          end else if (out_chan_inc <= {1'b0, out_depth_last}) begin
            out_chan_next = out_chan_inc[D-1:0];
            out_row_next  = '0;
            out_col_next  = '0;
            phase_next    = PH_PSTART;
          end else begin
            phase_next = PH_GAP;
          end
        end
      end
      PH_GAP: begin
        phase_next = PH_LDONE;
      end
      PH_LDONE: begin
        phase_next = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // State updates only on an accepted tick, stage-one valid on every adv
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_BOOT;
      out_chan <= '0;
      out_row  <= '0;
      out_col  <= '0;
      in_chan  <= '0;
      ker_row  <= '0;
      ker_col  <= '0;
      load     <= 1'b0;
      valid1   <= 1'b0;
    end else if (adv) begin
      valid1 <= in_valid;
      if (accept) begin
        phase    <= phase_next;
        out_chan <= out_chan_next;
        out_row  <= out_row_next;
        out_col  <= out_col_next;
        in_chan  <= in_chan_next;
        ker_row  <= ker_row_next;
        ker_col  <= ker_col_next;
        load     <= load_next;
      end
    end
  end

  // Flags of the tick held in stage one
  always_comb begin
    tok.valid       = valid1;
    tok.load        = load;
    tok.mac_valid   = (phase == PH_MAC);
    tok.pixel_start = (phase == PH_PSTART);
    tok.pixel_done  = (phase == PH_PDONE);
    tok.layer_done  = (phase == PH_LDONE);
  end

endmodule

// ----- sv/cas_addr.sv -----
// ----------------------------------------------------------------------------
// cas_addr
// Address datapath: a product stage followed by the sum and the result
// register. Addresses are held in the result register between loads.
// ----------------------------------------------------------------------------
module cas_addr #(
  parameter int DIM_BITS = 8,
  parameter int PW       = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cas_pkg::tok_t            tok,
  input  logic [DIM_BITS-1:0]      out_chan,
  input  logic [DIM_BITS-1:0]      in_chan,
  input  logic [DIM_BITS-1:0]      ker_row,
  input  logic [DIM_BITS-1:0]      ker_col,
  input  logic signed [DIM_BITS:0] win_y,
  input  logic signed [DIM_BITS:0] win_x,
  input  logic [DIM_BITS-1:0]      in_width_last,
  input  logic [DIM_BITS-1:0]      ker_width_last,
  input  logic [PW-1:0]            plane_size,
  input  logic [PW-1:0]            ker_plane_last,
  input  logic                     out_ready,
  output logic                     adv,
  output logic                     out_valid,
  output cas_pkg::out_t            out_data
);
  import cas_pkg::*;

  localparam int D = DIM_BITS;

  logic [D:0]                chan_sum;
  logic signed [D+1:0]       pos_y, pos_x;
  logic [D:0]                row_len, ker_len;
  logic [PW:0]               wplane;
  logic [D+PW:0]             plane_prod;
  logic signed [2*D+3:0]     row_prod;
  logic [D+PW:0]             wchan_prod;
  logic [2*D:0]              wrow_prod;

  tok_t                      tok2;
  logic                      valid2;
  logic [D+PW:0]             plane_q;
  logic signed [2*D+3:0]     row_q;
  logic signed [D+1:0]       pos_x_q;
  logic [D+PW:0]             wchan_q;
  logic [2*D:0]              wrow_q;
  logic [D-1:0]              ker_col_q;
  logic [IN_ADDR_W-1:0]      in_sum;
  logic [W_ADDR_W-1:0]       w_sum;

  // Whole pipeline moves when the result register is free or being drained
  assign adv = !out_valid || out_ready;

  // Products of the current positions
  always_comb begin
    chan_sum   = {1'b0, out_chan} + {1'b0, in_chan};
    pos_y      = $signed({win_y[D], win_y}) + $signed({2'b00, ker_row});
    pos_x      = $signed({win_x[D], win_x}) + $signed({2'b00, ker_col});
    row_len    = {1'b0, in_width_last} + (D+1)'(1);
    ker_len    = {1'b0, ker_width_last} + (D+1)'(1);
    wplane     = {1'b0, ker_plane_last} + (PW+1)'(1);
    plane_prod = (D+PW+1)'(chan_sum) * (D+PW+1)'(plane_size);
    row_prod   = (2*D+4)'(pos_y) * (2*D+4)'($signed({1'b0, row_len}));
    wchan_prod = (D+PW+1)'(in_chan) * (D+PW+1)'(wplane);
    wrow_prod  = (2*D+1)'(ker_row) * (2*D+1)'(ker_len);
  end

  // Register the products
  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else if (adv) begin
      valid2 <= tok.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok2      <= tok;
      plane_q   <= plane_prod;
      row_q     <= row_prod;
      pos_x_q   <= pos_x;
      wchan_q   <= wchan_prod;
      wrow_q    <= wrow_prod;
      ker_col_q <= ker_col;
    end
  end

  // Sum modulo the address widths
  assign in_sum = IN_ADDR_W'(plane_q) + IN_ADDR_W'(row_q) + IN_ADDR_W'(pos_x_q);
  assign w_sum  = W_ADDR_W'(wchan_q) + W_ADDR_W'(wrow_q) + W_ADDR_W'(ker_col_q);

  // Result register; addresses change only on a load tick
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_data  <= '0;
    end else if (adv) begin
      out_valid <= valid2;
      if (valid2) begin
        out_data.mac_valid   <= tok2.mac_valid;
        out_data.pixel_start <= tok2.pixel_start;
        out_data.pixel_done  <= tok2.pixel_done;
        out_data.layer_done  <= tok2.layer_done;
        if (tok2.load) begin
          out_data.input_addr  <= in_sum;
          out_data.weight_addr <= w_sum;
        end
      end
    end
  end

endmodule

// ----- sv/conv_address_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// conv_address_sequencer_core
// Convolution address sequencer: one input tick in, one result tick out,
// walking output pixels, input channels and kernel taps.
// ----------------------------------------------------------------------------
// Throughput: one tick per cycle while the result channel is not stalled;
// loop update, product stage and sum stage each take one register, in that
// order, between an accepted tick and its result on out_data.
// Reset: configuration clears to zero, the sequencer takes one boot tick and
// then sits idle; addresses read zero until the first load.
module conv_address_sequencer_core #(
  parameter int DIM_BITS   = 8,
  parameter int PLANE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  cas_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output cas_pkg::out_t                    out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cas_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cas_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import cas_pkg::*;

  localparam int D  = DIM_BITS;
  localparam int FB = (DIM_BITS < BYTE_W) ? DIM_BITS : BYTE_W;
  localparam int PW = (PLANE_BITS < CFG_DATA_W) ? PLANE_BITS : CFG_DATA_W;

  logic [CFG_DATA_W-1:0] depths, output_dims, input_dims, kernel_dims;
  logic [CFG_DATA_W-1:0] input_plane_size, kernel_plane_last;
  logic                  backward_mode;

  logic [D-1:0]          od_last, id_last, oh_last, ow_last;
  logic [D-1:0]          ih_last, iw_last, kh_last, kw_last;
  logic [PW-1:0]         plane_size, ker_plane_last;

  tok_t                  tok;
  logic                  adv;
  logic [D-1:0]          out_chan, in_chan, ker_row, ker_col;
  logic signed [D:0]     win_y, win_x;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      depths            <= '0;
      output_dims       <= '0;
      input_dims        <= '0;
      kernel_dims       <= '0;
      input_plane_size  <= '0;
      kernel_plane_last <= '0;
      backward_mode     <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEPTHS:            depths            <= cfg_data;
        CFG_OUTPUT_DIMS:       output_dims       <= cfg_data;
        CFG_INPUT_DIMS:        input_dims        <= cfg_data;
        CFG_KERNEL_DIMS:       kernel_dims       <= cfg_data;
        CFG_INPUT_PLANE_SIZE:  input_plane_size  <= cfg_data;
        CFG_KERNEL_PLANE_LAST: kernel_plane_last <= cfg_data;
        CFG_BACKWARD_MODE:     backward_mode     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Unpack the byte fields, masked to the dimension width
  assign od_last        = D'(depths[BYTE_W +: FB]);
  assign id_last        = D'(depths[FB-1:0]);
  assign oh_last        = D'(output_dims[BYTE_W +: FB]);
  assign ow_last        = D'(output_dims[FB-1:0]);
  assign ih_last        = D'(input_dims[BYTE_W +: FB]);
  assign iw_last        = D'(input_dims[FB-1:0]);
  assign kh_last        = D'(kernel_dims[BYTE_W +: FB]);
  assign kw_last        = D'(kernel_dims[FB-1:0]);
  assign plane_size     = input_plane_size[PW-1:0];
  assign ker_plane_last = kernel_plane_last[PW-1:0];

  assign in_ready = adv;

  // Loop sequencer
  cas_ctrl #(
    .DIM_BITS(DIM_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_data        (in_data),
    .adv            (adv),
    .out_depth_last (od_last),
    .in_depth_last  (id_last),
    .out_height_last(oh_last),
    .out_width_last (ow_last),
    .in_height_last (ih_last),
    .in_width_last  (iw_last),
    .ker_height_last(kh_last),
    .ker_width_last (kw_last),
    .bwd            (backward_mode),
    .tok            (tok),
    .out_chan       (out_chan),
    .in_chan        (in_chan),
    .ker_row        (ker_row),
    .ker_col        (ker_col),
    .win_y          (win_y),
    .win_x          (win_x)
  );

  // Address products, sums and result register
  cas_addr #(
    .DIM_BITS(DIM_BITS),
    .PW      (PW)
  ) u_addr (
    .clk           (clk),
    .rst           (rst),
    .tok           (tok),
    .out_chan      (out_chan),
    .in_chan       (in_chan),
    .ker_row       (ker_row),
    .ker_col       (ker_col),
    .win_y         (win_y),
    .win_x         (win_x),
    .in_width_last (iw_last),
    .ker_width_last(kw_last),
    .plane_size    (plane_size),
    .ker_plane_last(ker_plane_last),
    .out_ready     (out_ready),
    .adv           (adv),
    .out_valid     (out_valid),
    .out_data      (out_data)
  );

endmodule

// ----- dv/conv_address_sequencer_checker.sv -----
// ----------------------------------------------------------------------------
// conv_address_sequencer_checker
// Watches the tick, result and register-write channels of the convolution
// address sequencer. It keeps its own copy of the loop counters, the
// addresses and the registers, predicts the result of every accepted tick,
// and compares each result transfer field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module conv_address_sequencer_checker #(
  parameter int DIM_BITS   = 8,
  parameter int PLANE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  cas_pkg::in_t                   in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  cas_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [cas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cas_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             outstanding,
  output int                             pixels_done,
  output int                             layers_done
);
  timeunit 1ns;
  timeprecision 1ps;
  import cas_pkg::*;

  localparam int     DIM_MASK     = (1 << DIM_BITS) - 1;
  localparam longint PLANE_MASK   = (64'd1 << PLANE_BITS) - 1;
  localparam int     NUM_REGS     = 7;
  localparam int     REPORT_LIMIT = 10;

  typedef enum logic [2:0] {
    SEQ_BOOT, SEQ_IDLE, SEQ_PSTART, SEQ_MAC, SEQ_PDONE, SEQ_BUSY, SEQ_GAP, SEQ_LDONE
  } seq_phase_t;

  seq_phase_t            phase;
  int                    oc, orow, ocol, ic, kr, kc;
  logic [IN_ADDR_W-1:0]  in_addr_q;
  logic [W_ADDR_W-1:0]   w_addr_q;
  logic [CFG_DATA_W-1:0] regs [NUM_REGS];
  out_t                  expected_ticks [$];
  int                    errors = 0;
  int                    ticks_checked = 0;
  int                    pixel_count = 0;
  int                    layer_count = 0;

  // Register fields, high and low byte masked to the dimension width
  function automatic int dim_hi(int r);
    return int'(regs[r][15:8]) & DIM_MASK;
  endfunction

  function automatic int dim_lo(int r);
    return int'(regs[r][7:0]) & DIM_MASK;
  endfunction

  function automatic bit backward();
    return regs[CFG_BACKWARD_MODE][0];
  endfunction

  // Window origin, shifted up and left by the last kernel row and column in backward mode
  function automatic int win_row();
    return backward() ? orow - dim_hi(CFG_KERNEL_DIMS) : orow;
  endfunction

  function automatic int win_col();
    return backward() ? ocol - dim_lo(CFG_KERNEL_DIMS) : ocol;
  endfunction

  function automatic bit row_fits(int fy);
    return fy <= dim_hi(CFG_KERNEL_DIMS) &&
           (!backward() || win_row() + fy <= dim_hi(CFG_INPUT_DIMS));
  endfunction

  function automatic bit col_fits(int fx);
    return fx <= dim_lo(CFG_KERNEL_DIMS) &&
           (!backward() || win_col() + fx <= dim_lo(CFG_INPUT_DIMS));
  endfunction

  // First kernel row and column that land inside the input
  function automatic int row_start();
    int y;
    y = win_row();
    return (backward() && y < 0) ? -y : 0;
  endfunction

  function automatic int col_start();
    int x;
    x = win_col();
    return (backward() && x < 0) ? -x : 0;
  endfunction

  // Compute both addresses of the current tap, wrapped to the port widths
  function automatic void load_addrs();
    longint stride_in, stride_w, ia, wa;
    stride_in = longint'(regs[CFG_INPUT_PLANE_SIZE]) & PLANE_MASK;
    stride_w  = longint'(regs[CFG_KERNEL_PLANE_LAST]) & PLANE_MASK;
    ia = longint'(oc) * stride_in + longint'(ic) * stride_in
       + longint'(win_row() + kr) * longint'(dim_lo(CFG_INPUT_DIMS) + 1)
       + longint'(win_col() + kc);
    wa = longint'(ic) * (stride_w + 1)
       + longint'(kr) * longint'(dim_lo(CFG_KERNEL_DIMS) + 1) + longint'(kc);
    in_addr_q = ia[IN_ADDR_W-1:0];
    w_addr_q  = wa[W_ADDR_W-1:0];
  endfunction

  // Place the tap counters on the first surviving tap; 0 if the pixel is empty
  function automatic bit first_tap();
    int rf, cf;
    rf = row_start();
    cf = col_start();
    if (!row_fits(rf) || !col_fits(cf)) return 1'b0;
    ic = 0;
    kr = rf;
    kc = cf;
    return 1'b1;
  endfunction

  function automatic bit next_tap();
    if (col_fits(kc + 1)) begin
      kc++;
      return 1'b1;
    end
    if (row_fits(kr + 1) && col_fits(col_start())) begin
      kr++;
      kc = col_start();
      return 1'b1;
    end
    if (ic + 1 <= dim_lo(CFG_DEPTHS) && row_fits(row_start()) && col_fits(col_start())) begin
      ic++;
      kr = row_start();
      kc = col_start();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit next_pixel();
    if (ocol + 1 <= dim_lo(CFG_OUTPUT_DIMS)) begin
      ocol++;
      return 1'b1;
    end
    if (orow + 1 <= dim_hi(CFG_OUTPUT_DIMS)) begin
      orow++;
      ocol = 0;
      return 1'b1;
    end
    if (oc + 1 <= dim_hi(CFG_DEPTHS)) begin
      oc++;
      orow = 0;
      ocol = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the sequencer by one tick and form that tick's outputs
  function automatic out_t sequencer_tick(in_t t);
    out_t r;
    case (phase)
      SEQ_BOOT: phase = SEQ_IDLE;
      SEQ_IDLE: begin
        if (t.start_req) begin
          oc    = 0;
          orow  = 0;
          ocol  = 0;
          phase = SEQ_PSTART;
        end
      end
      SEQ_PSTART: begin
        if (first_tap()) begin
          load_addrs();
          phase = SEQ_MAC;
        end else begin
          phase = SEQ_PDONE;
        end
      end
      SEQ_MAC: begin
        if (next_tap()) load_addrs();
        else phase = SEQ_PDONE;
      end
      SEQ_PDONE: phase = SEQ_BUSY;
      SEQ_BUSY: begin
        if (!t.sink_busy) phase = next_pixel() ? SEQ_PSTART : SEQ_GAP;
      end
      SEQ_GAP: phase = SEQ_LDONE;
      default: phase = SEQ_IDLE;
    endcase
    r.mac_valid   = (phase == SEQ_MAC);
    r.input_addr  = in_addr_q;
    r.weight_addr = w_addr_q;
    r.pixel_start = (phase == SEQ_PSTART);
    r.pixel_done  = (phase == SEQ_PDONE);
    r.layer_done  = (phase == SEQ_LDONE);
    return r;
  endfunction

  task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("[%0t] result %0d: %s expected 0x%0h, got 0x%0h",
                 $realtime, ticks_checked, fname, want, got);
    end
  endtask

  // Track register writes, compare results, queue predictions
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      phase     = SEQ_BOOT;
      oc        = 0;
      orow      = 0;
      ocol      = 0;
      ic        = 0;
      kr        = 0;
      kc        = 0;
      in_addr_q = '0;
      w_addr_q  = '0;
      foreach (regs[i]) regs[i] = '0;
      expected_ticks.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BACKWARD_MODE)
          regs[CFG_BACKWARD_MODE] = {{(CFG_DATA_W-1){1'b0}}, cfg_data[0]};
        else if (cfg_index < CFG_BACKWARD_MODE)
          regs[cfg_index] = cfg_data;
      end

      if (out_valid && out_ready) begin
        if (expected_ticks.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("[%0t] result transfer with nothing expected", $realtime);
        end else begin
          want = expected_ticks.pop_front();
          check_field("mac_valid",   32'(want.mac_valid),   32'(out_data.mac_valid));
          check_field("input_addr",  32'(want.input_addr),  32'(out_data.input_addr));
          check_field("weight_addr", 32'(want.weight_addr), 32'(out_data.weight_addr));
          check_field("pixel_start", 32'(want.pixel_start), 32'(out_data.pixel_start));
          check_field("pixel_done",  32'(want.pixel_done),  32'(out_data.pixel_done));
          check_field("layer_done",  32'(want.layer_done),  32'(out_data.layer_done));
          ticks_checked++;
        end
      end

      if (in_valid && in_ready) begin
        want = sequencer_tick(in_data);
        expected_ticks.push_back(want);
        if (want.pixel_done) pixel_count++;
        if (want.layer_done) layer_count++;
      end
    end
    mismatches  <= errors;
    outstanding <= expected_ticks.size();
    pixels_done <= pixel_count;
    layers_done <= layer_count;
  end

endmodule

// ----- dv/conv_address_sequencer_core_tb.sv -----
// ----------------------------------------------------------------------------
// conv_address_sequencer_core_tb
// Drives ticks and register settings into the convolution address sequencer
// with random idling on both channels. A short directed layer under reset
// values and a full-scale setting come first, then random settings: small
// forward and backward layers, edge-clipped layers with empty pixels,
// full-range values and single-register rewrites in the middle of a layer.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module conv_address_sequencer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cas_pkg::*;

  localparam int TICK_TARGET = 1450;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 8;
  localparam int NUM_REGS    = 7;

  // Index past the last register; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 3'd7;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  in_t                   in_data   = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_ready;
  logic                  out_valid;
  out_t                  out_data;
  logic                  cfg_ready;

  int mismatches, outstanding, pixels_done, layers_done;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int ticks_sent     = 0;
  int settings_used  = 0;
  int cycle_count    = 0;

  conv_address_sequencer_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  conv_address_sequencer_checker seq_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .pixels_done (pixels_done),
    .layers_done (layers_done)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, outstanding);
      $display("FAILURE");
      $finish;
    end
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic logic [15:0] pack_dims(int hi, int lo);
    return {8'(hi), 8'(lo)};
  endfunction

  // Send one tick; the sender may idle first, valid holds until the transfer
  task automatic send_tick(input logic start, input logic busy);
    in_t t;
    if (ticks_sent < TICK_TARGET / 3) begin
      send_idle_pct = 35;
      recv_idle_pct = 70;
    end else if (ticks_sent < 2 * TICK_TARGET / 3) begin
      send_idle_pct = 70;
      recv_idle_pct = 35;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    t.start_req = start;
    t.sink_busy = busy;
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic run_ticks(int n, int start_pct, int busy_pct);
    repeat (n) send_tick($urandom_range(0, 99) < start_pct, $urandom_range(0, 99) < busy_pct);
  endtask

  // Hold valid high across back-to-back writes; the caller drops it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [15:0] setting [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) write_reg(i[CFG_IDX_W-1:0], setting[i]);
    write_reg(CFG_SPARE_INDEX, 16'($urandom_range(0, 65535)));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Stop sending and wait until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    logic [15:0] setting [NUM_REGS];
    int          mode;
    int          burst;
    bit          full;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // One-pixel layer under reset values: boot tick, start, start ignored
    // while running, busy hold, start ignored in the busy wait
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    drain();

    // Every register at full scale, backward mode on
    foreach (setting[i]) setting[i] = 16'hFFFF;
    apply_setting(setting);
    send_tick(1'b1, 1'b0);
    run_ticks(11, 50, 50);
    drain();

    // Random settings until the tick budget is spent
    while (ticks_sent < TICK_TARGET) begin
      mode = $urandom_range(0, 9);
      if (mode == 8 && settings_used > 2) begin
        // Rewrite one register while a layer may be running
        write_reg(3'($urandom_range(0, 7)),
                  pack_dims($urandom_range(0, 3), $urandom_range(0, 3)));
        cfg_valid <= 1'b0;
        settings_used++;
      end else begin
        if (mode >= 5 && mode <= 6) begin
          // Output larger than input: clipped taps and empty pixels
          setting[CFG_DEPTHS]      = pack_dims($urandom_range(0, 1), $urandom_range(0, 1));
          setting[CFG_OUTPUT_DIMS] = pack_dims($urandom_range(1, 3), $urandom_range(1, 3));
          setting[CFG_INPUT_DIMS]  = pack_dims($urandom_range(0, 1), $urandom_range(0, 1));
          setting[CFG_KERNEL_DIMS] = pack_dims($urandom_range(0, 2), $urandom_range(0, 2));
          setting[CFG_BACKWARD_MODE] = 16'h0001;
        end else if (mode == 7) begin
          foreach (setting[i]) setting[i] = 16'($urandom_range(0, 65535));
        end else if (mode == 9) begin
          full = $urandom_range(0, 1);
          foreach (setting[i]) setting[i] = full ? 16'hFFFF : 16'h0000;
        end else begin
          setting[CFG_DEPTHS]      = pack_dims($urandom_range(0, 1), $urandom_range(0, 1));
          setting[CFG_OUTPUT_DIMS] = pack_dims($urandom_range(0, 1), $urandom_range(0, 2));
          setting[CFG_INPUT_DIMS]  = pack_dims($urandom_range(0, 5), $urandom_range(0, 5));
          setting[CFG_KERNEL_DIMS] = pack_dims($urandom_range(0, 2), $urandom_range(0, 2));
          setting[CFG_BACKWARD_MODE] = 16'($urandom_range(0, 1));
        end
        if (mode != 7 && mode != 9) begin
          setting[CFG_INPUT_PLANE_SIZE]  = 16'($urandom_range(0, 65535));
          setting[CFG_KERNEL_PLANE_LAST] = 16'($urandom_range(0, 65535));
        end
        apply_setting(setting);
      end
      // Keep the last burst inside the tick budget
      burst = $urandom_range(60, 180);
      if (burst > TICK_TARGET - ticks_sent) burst = TICK_TARGET - ticks_sent;
      run_ticks(burst, 70, $urandom_range(0, 60));
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d ticks under %0d register settings, forward and backward.",
             ticks_sent, settings_used);
    $display("Predicted %0d finished pixels and %0d finished layers.",
             pixels_done, layers_done);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
